FILE: hw/rtl/gio_pkg.sv
package gio_pkg;

    // Field and register widths
    localparam int CELL_W     = 16;
    localparam int SIDE_CFG_W = 9;
    localparam int RAD_CFG_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Largest radius the radius register can express
    localparam int RAD_CFG_MAX = 7;

    // Largest side the side register can express
    localparam int SIDE_CFG_MAX = 511;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAP_SIDE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_CELLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INFLATED_CODE = 3'd3;

    // Control flags carried by every window cell
    typedef struct packed {
        logic valid;
        logic obst;
    } flags_t;

    // Cell codes used by the result logic
    typedef struct packed {
        logic [CELL_W-1:0] obstacle;
        logic [CELL_W-1:0] inflated;
    } codes_t;

endpackage

FILE: hw/rtl/gio_cell.sv
module gio_cell #(
    parameter int ROW_W = 10,
    parameter int COL_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic                        clear,
    input  gio_pkg::flags_t             d_flags,
    input  logic [ROW_W-1:0]            d_row,
    input  logic [COL_W-1:0]            d_col,
    input  logic [gio_pkg::CELL_W-1:0]  d_value,
    input  logic [ROW_W-1:0]            center_row,
    output gio_pkg::flags_t             q_flags,
    output logic [ROW_W-1:0]            q_row,
    output logic [COL_W-1:0]            q_col,
    output logic [gio_pkg::CELL_W-1:0]  q_value,
    output logic                        hit
);

    gio_pkg::flags_t            flags_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [COL_W-1:0]           col_reg;
    logic [gio_pkg::CELL_W-1:0] value_reg;

    // Take the neighbor's slot; drop everything on a frame restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else if (shift)
        begin
            flags_reg <= d_flags;
        end
    end

    // Hold position tags and cell code of the slot
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            row_reg   <= d_row;
            col_reg   <= d_col;
            value_reg <= d_value;
        end
    end

    // An obstacle counts only within the row of the window center
    assign hit = flags_reg.valid & flags_reg.obst & (row_reg == center_row);

    assign q_flags = flags_reg;
    assign q_row   = row_reg;
    assign q_col   = col_reg;
    assign q_value = value_reg;

endmodule

FILE: hw/rtl/gio_line_buf.sv
module gio_line_buf #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 126
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write one column word; read with write-first forwarding
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/gio_vert.sv
module gio_vert #(
    parameter int ROW_W = 10,
    parameter int COL_W = 8,
    parameter int SW    = 9,
    parameter int RL    = 7,
    parameter int DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        h_in,
    input  logic [ROW_W-1:0]            row_in,
    input  logic [COL_W-1:0]            col_in,
    input  logic [gio_pkg::CELL_W-1:0]  value_in,
    input  logic [SW-1:0]               side_u,
    input  logic [gio_pkg::RAD_CFG_W-1:0] r_u,
    input  gio_pkg::codes_t             codes,
    output logic                        ready,
    output logic                        res_valid,
    output logic [gio_pkg::CELL_W-1:0]  res_cell,
    output logic                        res_last,
    input  logic                        res_ready
);

    localparam int CW     = gio_pkg::CELL_W;
    localparam int HBITS  = 2 * RL;
    localparam int WORD_W = HBITS + RL * CW;

    logic                 s2v_reg;
    logic                 s2v_next;
    logic                 h_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [CW-1:0]        val_reg;

    logic [WORD_W-1:0]    rd_word;
    logic [WORD_W-1:0]    wr_word;
    logic                 s2_out;
    logic                 s2_move;
    logic                 vor;
    logic [CW-1:0]        vc;
    logic [ROW_W-1:0]     y;
    logic [SW-1:0]        side_m1;
    logic [3:0]           two_r;

    // Column history: h bits of the last rows, then cell codes of the last rows
    gio_line_buf #(
        .DEPTH (DEPTH),
        .AW    (COL_W),
        .DW    (WORD_W)
    ) u_line_buf (
        .clk   (clk),
        .re    (load),
        .raddr (col_in),
        .we    (s2_move),
        .waddr (col_reg),
        .wdata (wr_word),
        .rdata (rd_word)
    );

    // Advance the stage when the result slot frees up or no result is due
    assign s2_move = s2v_reg & (~s2_out | res_ready);
    assign ready   = ~s2v_reg | s2_move;

    always_comb
    begin
        s2v_next = s2v_reg;
        if (load)
        begin
            s2v_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2v_reg <= 1'b0;
        end
        else
        begin
            s2v_reg <= s2v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            h_reg   <= h_in;
            row_reg <= row_in;
            col_reg <= col_in;
            val_reg <= value_in;
        end
    end

    // Output cell sits radius rows above the newest row of the column
    assign y       = row_reg - ROW_W'(r_u);
    assign side_m1 = side_u - SW'(1);
    assign two_r   = {r_u, 1'b0};
    assign s2_out  = (row_reg >= ROW_W'(r_u)) && (y < ROW_W'(side_u));

    // OR the column over the rows in range, skipping rows above the map
    always_comb
    begin
        vor = h_reg;
        for (int i = 0; i < HBITS; i++)
        begin
            if ((4'(i) < two_r) && (ROW_W'(i) < row_reg))
            begin
                vor = vor | rd_word[i];
            end
        end
    end

    // Pick the code of the output cell from the column history
    always_comb
    begin
        vc = val_reg;
        for (int i = 0; i < RL; i++)
        begin
            if (r_u == gio_pkg::RAD_CFG_W'(i + 1))
            begin
                vc = rd_word[HBITS + i * CW +: CW];
            end
        end
    end

    // Shift the column history by one row
    always_comb
    begin
        wr_word = '0;
        wr_word[0] = h_reg;
        for (int i = 1; i < HBITS; i++)
        begin
            wr_word[i] = rd_word[i - 1];
        end
        wr_word[HBITS +: CW] = val_reg;
        for (int i = 1; i < RL; i++)
        begin
            wr_word[HBITS + i * CW +: CW] = rd_word[HBITS + (i - 1) * CW +: CW];
        end
    end

    assign res_valid = s2v_reg & s2_out;
    assign res_cell  = (vc == codes.obstacle) ? vc : (vor ? codes.inflated : vc);
    assign res_last  = (y == ROW_W'(side_m1)) && (col_reg == COL_W'(side_m1));

endmodule

FILE: hw/rtl/grid_obstacle_inflation.sv
// Result order: the result for cell k leaves with the item at raster position
//   k + radius*side + radius; it passes the column stage and the output register.
// Throughput: one item per cycle unless the output stalls; no item is taken in the cycle after reset
//   or after a configuration write. Window cells and counters are the limit.
// Reset: control registers take their defaults, the frame restarts at position zero;
//   the column memory is not cleared, rows above the map are masked by count.
module grid_obstacle_inflation #(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // [15:0] cell_in
    input  logic                               s_axis_tuser,  // [0] flush
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [15:0] cell_out
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gio_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gio_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW       = gio_pkg::CELL_W;
    localparam int RADW     = gio_pkg::RAD_CFG_W;
    localparam int SIDE_LIM = (MAX_SIDE < gio_pkg::SIDE_CFG_MAX) ? MAX_SIDE
                                                                 : gio_pkg::SIDE_CFG_MAX;
    localparam int RL       = (MAX_RADIUS < gio_pkg::RAD_CFG_MAX) ? MAX_RADIUS
                                                                  : gio_pkg::RAD_CFG_MAX;
    localparam int SW       = $clog2(SIDE_LIM + 1);
    localparam int COL_W    = $clog2(SIDE_LIM);
    localparam int ROW_W    = $clog2(SIDE_LIM + 2 * RL + 1);
    localparam int END_MAX  = (SIDE_LIM + RL) * SIDE_LIM + RL - 1;
    localparam int P_W      = $clog2(END_MAX + 1);
    localparam int CHAIN    = 2 * RL;

    // Configuration registers
    logic [gio_pkg::SIDE_CFG_W-1:0] side_reg;
    logic [RADW-1:0]                rad_reg;
    gio_pkg::codes_t                codes_reg;
    logic                           cfg_hit;
    logic                           settle_reg;

    // Values derived from the configuration
    logic [SW-1:0]   side_u_c;
    logic [RADW-1:0] r_u_c;
    logic [P_W-1:0]  end_c;
    logic [SW-1:0]   side_u_reg;
    logic [RADW-1:0] r_u_reg;
    logic [P_W-1:0]  end_reg;

    // Raster position of the next item
    logic [P_W-1:0]   p_lin_reg;
    logic [P_W-1:0]   p_lin_next;
    logic [ROW_W-1:0] p_row_reg;
    logic [ROW_W-1:0] p_row_next;
    logic [COL_W-1:0] p_col_reg;
    logic [COL_W-1:0] p_col_next;

    logic            in_acc;
    logic            phase_cells;
    logic            adv;
    logic            at_end;
    logic            restart;
    logic [SW-1:0]   side_m1;
    logic [3:0]      two_r;

    // Window: slot 0 is the item being taken, the rest are chain cells
    gio_pkg::flags_t  w_flags [CHAIN + 1];
    logic [ROW_W-1:0] w_row   [CHAIN + 1];
    logic [COL_W-1:0] w_col   [CHAIN + 1];
    logic [CW-1:0]    w_val   [CHAIN + 1];
    logic             cell_hit [CHAIN];

    gio_pkg::flags_t  ctr_flags;
    logic [ROW_W-1:0] ctr_row;
    logic [COL_W-1:0] ctr_col;
    logic [CW-1:0]    ctr_val;
    logic             new_obst;
    logic             h_win;

    logic             vert_ready;
    logic             res_valid;
    logic [CW-1:0]    res_cell;
    logic             res_last;
    logic             res_ready;

    logic             out_v_reg;
    logic             out_v_next;
    logic [CW-1:0]    out_data_reg;
    logic             out_last_reg;

    // Decode configuration writes; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (cfg_index)
            gio_pkg::REG_MAP_SIDE:      cfg_hit = cfg_valid;
            gio_pkg::REG_RADIUS_CELLS:  cfg_hit = cfg_valid;
            gio_pkg::REG_OBSTACLE_CODE: cfg_hit = cfg_valid;
            gio_pkg::REG_INFLATED_CODE: cfg_hit = cfg_valid;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg           <= 9'd256;
            rad_reg            <= 3'd2;
            codes_reg.obstacle <= 16'hFFFF;
            codes_reg.inflated <= 16'hFFFE;
            settle_reg         <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_hit;
            if (cfg_valid)
            begin
                case (cfg_index)
                    gio_pkg::REG_MAP_SIDE:
                        side_reg <= cfg_data[gio_pkg::SIDE_CFG_W-1:0];
                    gio_pkg::REG_RADIUS_CELLS:
                        rad_reg <= cfg_data[RADW-1:0];
                    gio_pkg::REG_OBSTACLE_CODE:
                        codes_reg.obstacle <= cfg_data[CW-1:0];
                    gio_pkg::REG_INFLATED_CODE:
                        codes_reg.inflated <= cfg_data[CW-1:0];
                    default:
                        side_reg <= side_reg;
                endcase
            end
        end
    end

    // Clamp side and radius, find the position of the last padding item
    always_comb
    begin
        if (side_reg == '0)
        begin
            side_u_c = SW'(1);
        end
        else if (side_reg > gio_pkg::SIDE_CFG_W'(SIDE_LIM))
        begin
            side_u_c = SW'(SIDE_LIM);
        end
        else
        begin
            side_u_c = SW'(side_reg);
        end
        r_u_c = (rad_reg > RADW'(RL)) ? RADW'(RL) : rad_reg;
        end_c = P_W'((P_W'(side_u_c) + P_W'(r_u_c)) * P_W'(side_u_c)
                     + P_W'(r_u_c) - P_W'(1));
    end

    always_ff @(posedge clk)
    begin
        side_u_reg <= side_u_c;
        r_u_reg    <= r_u_c;
        end_reg    <= end_c;
    end

    // Take an item; drop it when it does not fit the frame phase
    assign s_axis_tready = ~settle_reg & vert_ready;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign phase_cells   = p_row_reg < ROW_W'(side_u_reg);
    assign adv           = in_acc & (phase_cells ? ~s_axis_tuser : s_axis_tuser);
    assign at_end        = p_lin_reg == end_reg;
    assign restart       = (adv & at_end) | cfg_hit;
    assign side_m1       = side_u_reg - SW'(1);
    assign two_r         = {r_u_reg, 1'b0};

    // Advance the raster position
    always_comb
    begin
        p_lin_next = p_lin_reg;
        p_row_next = p_row_reg;
        p_col_next = p_col_reg;
        if (restart)
        begin
            p_lin_next = '0;
            p_row_next = '0;
            p_col_next = '0;
        end
        else if (adv)
        begin
            p_lin_next = p_lin_reg + P_W'(1);
            if (p_col_reg == COL_W'(side_m1))
            begin
                p_col_next = '0;
                p_row_next = p_row_reg + ROW_W'(1);
            end
            else
            begin
                p_col_next = p_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_lin_reg <= '0;
            p_row_reg <= '0;
            p_col_reg <= '0;
        end
        else
        begin
            p_lin_reg <= p_lin_next;
            p_row_reg <= p_row_next;
            p_col_reg <= p_col_next;
        end
    end

    // Slot 0 of the window is the incoming item
    assign new_obst       = ~s_axis_tuser & (s_axis_tdata == codes_reg.obstacle);
    assign w_flags[0]     = '{valid: 1'b1, obst: new_obst};
    assign w_row[0]       = p_row_reg;
    assign w_col[0]       = p_col_reg;
    assign w_val[0]       = s_axis_tdata;

    // Chain of window cells, each shifting to its neighbor per item
    for (genvar t = 0; t < CHAIN; t++)
    begin : g_chain
        gio_cell #(
            .ROW_W (ROW_W),
            .COL_W (COL_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (adv),
            .clear      (restart),
            .d_flags    (w_flags[t]),
            .d_row      (w_row[t]),
            .d_col      (w_col[t]),
            .d_value    (w_val[t]),
            .center_row (ctr_row),
            .q_flags    (w_flags[t + 1]),
            .q_row      (w_row[t + 1]),
            .q_col      (w_col[t + 1]),
            .q_value    (w_val[t + 1]),
            .hit        (cell_hit[t])
        );
    end

    // Select the window center, radius slots behind the newest item
    always_comb
    begin
        ctr_flags = w_flags[0];
        ctr_row   = w_row[0];
        ctr_col   = w_col[0];
        ctr_val   = w_val[0];
        for (int t = 1; t <= RL; t++)
        begin
            if (r_u_reg == RADW'(t))
            begin
                ctr_flags = w_flags[t];
                ctr_row   = w_row[t];
                ctr_col   = w_col[t];
                ctr_val   = w_val[t];
            end
        end
    end

    // OR the obstacles of the row segment around the center
    always_comb
    begin
        h_win = new_obst & (p_row_reg == ctr_row);
        for (int t = 1; t <= CHAIN; t++)
        begin
            if (4'(t) <= two_r)
            begin
                h_win = h_win | cell_hit[t - 1];
            end
        end
    end

    // Column stage: line history, vertical OR and result code
    gio_vert #(
        .ROW_W (ROW_W),
        .COL_W (COL_W),
        .SW    (SW),
        .RL    (RL),
        .DEPTH (SIDE_LIM)
    ) u_vert (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv & ctr_flags.valid),
        .h_in      (h_win),
        .row_in    (ctr_row),
        .col_in    (ctr_col),
        .value_in  (ctr_val),
        .side_u    (side_u_reg),
        .r_u       (r_u_reg),
        .codes     (codes_reg),
        .ready     (vert_ready),
        .res_valid (res_valid),
        .res_cell  (res_cell),
        .res_last  (res_last),
        .res_ready (res_ready)
    );

    // Output register
    assign res_ready = ~out_v_reg | m_axis_tready;

    always_comb
    begin
        out_v_next = out_v_reg;
        if (res_valid && res_ready)
        begin
            out_v_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_cell;
            out_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_settle_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !(s_axis_tvalid && s_axis_tready))
        else $error("item taken before derived configuration settled");

    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && at_end) |=> (p_lin_reg == '0 && p_row_reg == '0 && p_col_reg == '0))
        else $error("frame did not restart after the last padding item");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !settle_reg |-> (p_lin_reg <= end_reg))
        else $error("raster position ran past the end of the frame");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_last) |-> (p_lin_reg == '0))
        else $error("last cell pending while the frame position did not restart");
`endif

endmodule
